/* rtl/core/uhpb_pkg.sv */
// ----------------------------------------------------------------------------
// uhpb_pkg
// shared types, register codes and fixed-point constants of the haze blend
// ----------------------------------------------------------------------------
`default_nettype none

package uhpb_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN_RED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN_GREEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN_BLUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKDROP_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKDROP_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKDROP_BLUE  = 3'd5;

  localparam logic [15:0] ATTEN_RESET = 16'd137;
  localparam logic [7:0]  BACKDROP_RESET = 8'd0;

  // exp series and integer-power sections
  localparam int unsigned SERIES_TERMS  = 13;
  localparam int unsigned TERM_STAGES   = 3;
  localparam int unsigned EXP_INT_LIMIT = 24;
  localparam int unsigned POW_STAGES    = EXP_INT_LIMIT - 1;
  localparam int unsigned ACC_W         = 35;

  // lane latency: product, series init, series terms, powers, transmittance, blend
  localparam int unsigned LANE_LAT =
    2 + (SERIES_TERMS - 1) * TERM_STAGES + POW_STAGES + 2;

  // exp(-1/2) in q0.32 by the truncated series, then squared
  function automatic logic [31:0] calc_e1();
    logic [63:0] term;
    logic [63:0] h;
    logic [63:0] sq;
    term = 64'd1 << 32;
    h    = term;
    for (int k = 1; k <= 13; k++) begin
      term = (term >> 1) / 64'(k);
      if (k % 2 == 1) begin
        h = h - term;
      end else begin
        h = h + term;
      end
    end
    sq = h * h;
    return sq[63:32];
  endfunction

  localparam logic [31:0] E1_Q32 = calc_e1();

  typedef struct packed {
    logic [15:0] atten;
    logic [7:0]  backdrop;
  } lane_cfg_t;

  typedef struct packed {
    logic [7:0] pix;
    logic [4:0] n;
    logic       force_one;
    logic       force_zero;
  } side_t;

endpackage

`default_nettype wire

/* rtl/core/underwater_haze_pixel_blend.sv */
// ----------------------------------------------------------------------------
// underwater_haze_pixel_blend
// blends each pixel toward the water backdrop by per-channel transmittance
// throughput: one pixel per cycle while the output is not stalled; three channel lanes run side by side
// most of the pipeline depth comes from the 12 series terms (3 stages each) and 23 power stages
// a stalled output holds the whole pipeline only while its last stage is full
// reset: clears all valid flags and reloads the six registers with defaults
// ----------------------------------------------------------------------------
`default_nettype none

module underwater_haze_pixel_blend #(
  parameter int unsigned TRANS_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // pix_red, pix_green, pix_blue, depth_val, range_factor
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [uhpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  import uhpb_pkg::*;

  logic [15:0] atten_red, atten_green, atten_blue;
  logic [7:0]  backdrop_red, backdrop_green, backdrop_blue;

  logic        adv;
  logic        vld [0:LANE_LAT];
  logic [31:0] prod;
  logic [7:0]  pix_r, pix_g, pix_b;
  logic [15:0] range_val;
  logic [7:0]  res_r, res_g, res_b;
  lane_cfg_t   cfg_r, cfg_g, cfg_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      atten_red      <= ATTEN_RESET;
      atten_green    <= ATTEN_RESET;
      atten_blue     <= ATTEN_RESET;
      backdrop_red   <= BACKDROP_RESET;
      backdrop_green <= BACKDROP_RESET;
      backdrop_blue  <= BACKDROP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTEN_RED:      atten_red      <= cfg_data;
        REG_ATTEN_GREEN:    atten_green    <= cfg_data;
        REG_ATTEN_BLUE:     atten_blue     <= cfg_data;
        REG_BACKDROP_RED:   backdrop_red   <= cfg_data[7:0];
        REG_BACKDROP_GREEN: backdrop_green <= cfg_data[7:0];
        REG_BACKDROP_BLUE:  backdrop_blue  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_r = '{atten: atten_red,   backdrop: backdrop_red};
  assign cfg_g = '{atten: atten_green, backdrop: backdrop_green};
  assign cfg_b = '{atten: atten_blue,  backdrop: backdrop_blue};

  // pipeline moves unless a finished beat would collide with a held output
  assign adv      = !vld[LANE_LAT] || !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LANE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i <= LANE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= 32'(s_tdata[39:24]) * 32'(s_tdata[55:40]);
      pix_r <= s_tdata[7:0];
      pix_g <= s_tdata[15:8];
      pix_b <= s_tdata[23:16];
    end
  end

  // range in q8.8, saturated
  assign range_val = (prod[31:30] != 2'b00) ? 16'hFFFF : prod[29:14];

  uhpb_lane #(.TRANS_BITS(TRANS_BITS)) u_lane_r (
    .clk(clk), .en(adv), .cfg(cfg_r), .range_val(range_val), .pix(pix_r), .pix_out(res_r)
  );
  uhpb_lane #(.TRANS_BITS(TRANS_BITS)) u_lane_g (
    .clk(clk), .en(adv), .cfg(cfg_g), .range_val(range_val), .pix(pix_g), .pix_out(res_g)
  );
  uhpb_lane #(.TRANS_BITS(TRANS_BITS)) u_lane_b (
    .clk(clk), .en(adv), .cfg(cfg_b), .range_val(range_val), .pix(pix_b), .pix_out(res_b)
  );

  // merge lanes into the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (adv && vld[LANE_LAT]) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[LANE_LAT]) begin
      m_tdata <= {res_b, res_g, res_r};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  assert property (@(posedge clk) disable iff (rst)
    vld[LANE_LAT] && m_tvalid && !m_tready |-> !s_tready)
    else $error("pipeline advanced into a held output");

  assert property (@(posedge clk) disable iff (rst)
    !adv && vld[LANE_LAT] |=> vld[LANE_LAT] && m_tvalid)
    else $error("finished beat lost during stall");

endmodule

`default_nettype wire

/* rtl/core/uhpb_term.sv */
// ----------------------------------------------------------------------------
// uhpb_term
// one term of the exp(-f) series: multiply by f, divide by k, accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module uhpb_term #(
  parameter int unsigned K = 2
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [31:0]                  term_in,
  input  wire logic signed [uhpb_pkg::ACC_W-1:0] acc_in,
  input  wire logic [19:0]                  f_in,
  output logic [31:0]                       term_out,
  output logic signed [uhpb_pkg::ACC_W-1:0] acc_out,
  output logic [19:0]                       f_out
);
  import uhpb_pkg::*;

  localparam logic [31:0] KW    = 32'(K);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
  localparam bit          SUB   = (K % 2) == 1;

  logic [31:0]              v_a;
  logic [19:0]              f_a;
  logic signed [ACC_W-1:0]  acc_a;
  logic [31:0]              v_b;
  logic [31:0]              q0_b;
  logic [19:0]              f_b;
  logic signed [ACC_W-1:0]  acc_b;

  logic [51:0] prod_a;
  logic [63:0] prod_b;
  logic [31:0] rem;
  logic [31:0] q;
  logic signed [ACC_W-1:0] q_ext;

  assign prod_a = 52'(term_in) * 52'(f_in);
  assign prod_b = 64'(v_a) * 64'(RECIP);
  assign rem    = v_b - 32'(q0_b * KW);
  assign q      = (rem >= KW) ? q0_b + 32'd1 : q0_b;
  assign q_ext  = $signed({3'b000, q});

  always_ff @(posedge clk) begin
    if (en) begin
      v_a   <= prod_a[51:20];
      f_a   <= f_in;
      acc_a <= acc_in;
      v_b   <= v_a;
      q0_b  <= prod_b[63:32];
      f_b   <= f_a;
      acc_b <= acc_a;
      term_out <= q;
      f_out    <= f_b;
      acc_out  <= SUB ? acc_b - q_ext : acc_b + q_ext;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/uhpb_lane.sv */
// ----------------------------------------------------------------------------
// uhpb_lane
// one color channel: attenuation product, exp series, integer powers, blend
// ----------------------------------------------------------------------------
`default_nettype none

module uhpb_lane #(
  parameter int unsigned TRANS_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire uhpb_pkg::lane_cfg_t cfg,
  input  wire logic [15:0]         range_val,
  input  wire logic [7:0]          pix,
  output logic [7:0]               pix_out
);
  import uhpb_pkg::*;

  localparam int unsigned TERM_LEN = (SERIES_TERMS - 1) * TERM_STAGES;
  localparam logic [TRANS_BITS:0] ONE = {1'b1, {TRANS_BITS{1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_ONE = $signed(ACC_W'(64'd1 << 32));

  // product stage
  logic [31:0] x1;
  side_t       side1;

  // series
  logic [31:0]             term_w [0:SERIES_TERMS-1];
  logic signed [ACC_W-1:0] acc_w  [0:SERIES_TERMS-1];
  logic [19:0]             f_w    [0:SERIES_TERMS-1];
  side_t                   side_q [0:TERM_LEN];

  // integer powers
  logic [32:0] pw_p    [0:POW_STAGES];
  side_t       pw_side [0:POW_STAGES];

  // transmittance
  logic [TRANS_BITS:0] e_q;
  logic [7:0]          pix_e;
  logic [TRANS_BITS+8:0] mix;

  always_ff @(posedge clk) begin
    if (en) begin
      x1               <= 32'(range_val) * 32'(cfg.atten);
      side1.pix        <= pix;
      side1.n          <= '0;
      side1.force_one  <= cfg.atten == 16'd0;
      side1.force_zero <= range_val == 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_w[0]               <= x1[19:0];
      term_w[0]            <= {x1[19:0], 12'd0};
      acc_w[0]             <= ACC_ONE - $signed({3'b000, x1[19:0], 12'd0});
      side_q[0].pix        <= side1.pix;
      side_q[0].n          <= x1[24:20];
      side_q[0].force_one  <= side1.force_one;
      side_q[0].force_zero <= side1.force_zero || (x1[31:20] >= 12'(EXP_INT_LIMIT));
    end
  end

  for (genvar j = 0; j < SERIES_TERMS - 1; j++) begin : g_term
    uhpb_term #(
      .K(j + 2)
    ) u_term (
      .clk      (clk),
      .en       (en),
      .term_in  (term_w[j]),
      .acc_in   (acc_w[j]),
      .f_in     (f_w[j]),
      .term_out (term_w[j+1]),
      .acc_out  (acc_w[j+1]),
      .f_out    (f_w[j+1])
    );
  end

  for (genvar s = 0; s < TERM_LEN; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[s+1] <= side_q[s];
      end
    end
  end

  // clamp series sum to [0, 1]
  always_comb begin
    if (acc_w[SERIES_TERMS-1] < 0) begin
      pw_p[0] = '0;
    end else if (acc_w[SERIES_TERMS-1] > ACC_ONE) begin
      pw_p[0] = 33'h1_0000_0000;
    end else begin
      pw_p[0] = acc_w[SERIES_TERMS-1][32:0];
    end
  end
  assign pw_side[0] = side_q[TERM_LEN];

  for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
    logic [64:0] pw_prod;
    assign pw_prod = 65'(pw_p[i]) * 65'(E1_Q32);
    always_ff @(posedge clk) begin
      if (en) begin
        pw_p[i+1]    <= (5'(i) < pw_side[i].n) ? pw_prod[64:32] : pw_p[i];
        pw_side[i+1] <= pw_side[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_e <= pw_side[POW_STAGES].pix;
      if (pw_side[POW_STAGES].force_one) begin
        e_q <= ONE;
      end else if (pw_side[POW_STAGES].force_zero) begin
        e_q <= '0;
      end else begin
        e_q <= pw_p[POW_STAGES][32:32-TRANS_BITS];
      end
    end
  end

  assign mix = (TRANS_BITS+9)'(e_q) * (TRANS_BITS+9)'(pix_e)
             + (TRANS_BITS+9)'(ONE - e_q) * (TRANS_BITS+9)'(cfg.backdrop);

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out <= mix[TRANS_BITS+7:TRANS_BITS];
    end
  end

endmodule

`default_nettype wire

/* tb/underwater_haze_pixel_blend_test.sv */
// ----------------------------------------------------------------------------
// underwater_haze_pixel_blend_test
// streams pixels through the haze blend and checks every output beat against
// a fixed-point predictor of the per-channel transmittance and backdrop mix;
// runs directed corner pixels, extreme and random register settings, random
// stalls on both streams, and a final stretch at full rate
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module underwater_haze_pixel_blend_test;
  import uhpb_pkg::*;

  localparam int unsigned TRANS_W        = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_BACKDROP_BLUE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_BACKDROP_BLUE + 3'd2;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] depth;
    logic [15:0] factor;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [55:0]          s_tdata;   // pix_red, pix_green, pix_blue, depth_val, range_factor
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;   // out_red, out_green, out_blue
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  logic [15:0] atten_lane [3];
  logic [7:0]  backdrop_lane [3];
  logic [63:0] e_inv_q32;
  pixel_out_t  blended_q[$];
  int unsigned err_count = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_calm = 1'b0;
  int unsigned sink_left = 0;
  int unsigned quiet_cycles = 0;

  underwater_haze_pixel_blend #(
    .TRANS_BITS(TRANS_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exp(-f) in q0.32 by the truncated alternating series
  function automatic logic [63:0] exp_frac_q32(logic [63:0] frac);
    logic [63:0] term;
    longint      acc;
    term = 64'd1 << 32;
    acc  = longint'(term);
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 32)) begin
      acc = longint'(1) << 32;
    end
    return 64'(acc);
  endfunction

  function automatic logic [63:0] transmit_q(logic [63:0] rng, logic [15:0] att);
    logic [63:0] x;
    logic [63:0] whole;
    logic [63:0] p;
    if (att == 16'd0) begin
      return 64'd1 << TRANS_W;
    end
    if (rng == 64'd0) begin
      return 64'd0;
    end
    x     = rng * 64'(att);
    whole = x >> 20;
    if (whole >= EXP_INT_LIMIT) begin
      return 64'd0;
    end
    p = exp_frac_q32((x & 64'hFFFFF) << 12);
    for (int i = 0; i < int'(whole); i++) begin
      p = (p * e_inv_q32) >> 32;
    end
    return p >> (32 - TRANS_W);
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] pix, logic [7:0] bg, logic [63:0] e);
    logic [63:0] one;
    logic [63:0] sum;
    one = 64'd1 << TRANS_W;
    sum = e * 64'(pix) + (one - e) * 64'(bg);
    return sum[TRANS_W +: 8];
  endfunction

  function automatic pixel_out_t predict_pixel(pixel_in_t px);
    logic [63:0] rng;
    pixel_out_t  res;
    rng = (64'(px.depth) * 64'(px.factor)) >> 14;
    if (rng > 64'hFFFF) begin
      rng = 64'hFFFF;
    end
    res.red   = mix_channel(px.red,   backdrop_lane[0], transmit_q(rng, atten_lane[0]));
    res.green = mix_channel(px.green, backdrop_lane[1], transmit_q(rng, atten_lane[1]));
    res.blue  = mix_channel(px.blue,  backdrop_lane[2], transmit_q(rng, atten_lane[2]));
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      REG_ATTEN_RED:      atten_lane[0] = val;
      REG_ATTEN_GREEN:    atten_lane[1] = val;
      REG_ATTEN_BLUE:     atten_lane[2] = val;
      REG_BACKDROP_RED:   backdrop_lane[0] = val[7:0];
      REG_BACKDROP_GREEN: backdrop_lane[1] = val[7:0];
      REG_BACKDROP_BLUE:  backdrop_lane[2] = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t px;
    px.red   = rand_chan();
    px.green = rand_chan();
    px.blue  = rand_chan();
    case ($urandom_range(0, 7))
      0: begin
        px.depth  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        px.factor = (px.depth == 16'd0) ? 16'($urandom) : 16'd0;
      end
      1, 2: begin
        px.depth  = 16'($urandom);
        px.factor = 16'($urandom);
      end
      3, 4: begin
        px.depth  = 16'($urandom);
        px.factor = 16'($urandom_range(14000, 18000));
      end
      5: begin
        px.depth  = 16'($urandom_range(0, 512));
        px.factor = 16'($urandom);
      end
      default: begin
        px.depth  = 16'($urandom_range(0, 16'h3FFF));
        px.factor = 16'($urandom_range(0, 16'h3FFF));
      end
    endcase
    return px;
  endfunction

  function automatic logic [15:0] rand_atten();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      5:       return 16'($urandom_range(1, 8191));
      default: return 16'($urandom_range(1, 600));
    endcase
  endfunction

  function automatic logic [15:0] rand_backdrop();
    logic [15:0] word;
    word = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       word[7:0] = 8'h00;
      1:       word[7:0] = 8'hFF;
      default: ;
    endcase
    return word;
  endfunction

  task automatic send_pixel(pixel_in_t px);
    s_tvalid <= 1'b1;
    s_tdata  <= {px.factor, px.depth, px.blue, px.green, px.red};
    do @(posedge clk); while (!s_tready);
    blended_q.push_back(predict_pixel(px));
  endtask

  task automatic src_pause();
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic stream_pixels(int unsigned count);
    repeat (count) begin
      src_pause();
      send_pixel(rand_pixel());
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (blended_q.size() != 0);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic program_regs(logic [15:0] att_r, logic [15:0] att_g, logic [15:0] att_b,
                              logic [15:0] bd_r, logic [15:0] bd_g, logic [15:0] bd_b);
    write_reg(REG_ATTEN_RED, att_r);
    write_reg(REG_ATTEN_GREEN, att_g);
    write_reg(REG_ATTEN_BLUE, att_b);
    write_reg(REG_BACKDROP_RED, bd_r);
    write_reg(REG_BACKDROP_GREEN, bd_g);
    write_reg(REG_BACKDROP_BLUE, bd_b);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(logic [23:0] beat);
    pixel_out_t want;
    if (blended_q.size() == 0) begin
      $error("unexpected output beat %h", beat);
      err_count++;
    end else begin
      want = blended_q.pop_front();
      if (beat[7:0] !== want.red) begin
        $error("out_red: expected %0d, got %0d", want.red, beat[7:0]);
        err_count++;
      end
      if (beat[15:8] !== want.green) begin
        $error("out_green: expected %0d, got %0d", want.green, beat[15:8]);
        err_count++;
      end
      if (beat[23:16] !== want.blue) begin
        $error("out_blue: expected %0d, got %0d", want.blue, beat[23:16]);
        err_count++;
      end
    end
  endtask

  // output side: check each beat, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
      end
      if (sink_calm) begin
        m_tready <= 1'b1;
      end else if (sink_left == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          m_tready  <= 1'b0;
          sink_left <= $urandom_range(1, 17);
        end else begin
          m_tready  <= 1'b1;
          sink_left <= $urandom_range(1, 40);
        end
      end else begin
        sink_left <= sink_left - 1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("underwater_haze_pixel_blend_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_default_config();
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0});
    send_pixel('{8'hFF, 8'h80, 8'h01, 16'd256, 16'd16384});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF});
    send_pixel('{8'h00, 8'h00, 8'h00, 16'd1000, 16'd100});
    send_pixel('{8'hC3, 8'h5A, 8'hFF, 16'd3000, 16'd20000});
  endtask

  task automatic test_special_ranges();
    drain_results();
    // writes to unused indexes must leave the lanes alone
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    program_regs(16'h0000, 16'hFFFF, 16'd4096, 16'hFFFF, 16'h0000, 16'h00AA);
    // zero range: zero attenuation passes the pixel, others give the backdrop
    send_pixel('{8'd10, 8'd200, 8'd90, 16'd0, 16'd5000});
    send_pixel('{8'd77, 8'd33, 8'd250, 16'd1, 16'd1});
    // range saturation
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF});
    // blue lane just below and at the integer cutoff
    send_pixel('{8'h00, 8'h80, 8'hFF, 16'd5888, 16'd16384});
    send_pixel('{8'h00, 8'h80, 8'hFF, 16'd6144, 16'd16384});
    // tiny ranges on the steep green lane
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 16'd1, 16'd16384});
    send_pixel('{8'h00, 8'hFF, 8'h00, 16'd17, 16'd16384});
    send_pixel('{8'h00, 8'h00, 8'h00, 16'd255, 16'd65535});
  endtask

  task automatic test_extreme_settings();
    drain_results();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'h00FF, 16'h00FF);
    stream_pixels(100);
    drain_results();
    program_regs(16'd1, 16'd1, 16'd1, 16'hFF00, 16'hFF00, 16'hFF00);
    stream_pixels(100);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      if ($urandom_range(0, 1) == 1) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
      end
      program_regs(rand_atten(), rand_atten(), rand_atten(),
                   rand_backdrop(), rand_backdrop(), rand_backdrop());
      if (ph == 2) begin
        stream_pixels(120);
        drain_results();
        stream_pixels(130);
      end else begin
        stream_pixels(250);
      end
    end
  endtask

  task automatic test_steady_stream();
    drain_results();
    program_regs(rand_atten(), rand_atten(), rand_atten(),
                 rand_backdrop(), rand_backdrop(), rand_backdrop());
    src_idle_en = 1'b0;
    sink_calm   = 1'b1;
    stream_pixels(280);
  endtask

  initial begin
    logic [63:0] half_exp;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int c = 0; c < 3; c++) begin
      atten_lane[c]    = ATTEN_RESET;
      backdrop_lane[c] = BACKDROP_RESET;
    end
    half_exp  = exp_frac_q32(64'd1 << 31);
    e_inv_q32 = (half_exp * half_exp) >> 32;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_default_config();
    test_special_ranges();
    test_extreme_settings();
    test_random_settings();
    test_steady_stream();

    drain_results();
    repeat (LANE_LAT + 32) @(posedge clk);
    if (err_count == 0) begin
      $display("underwater_haze_pixel_blend_test: clean");
    end else begin
      $display("underwater_haze_pixel_blend_test: errors");
    end
    $finish;
  end

endmodule
